// ===== src/ctt_pkg.sv =====
// Shared constants, codes and types of the console command tokenizer.
// Used by the lexer, the result queue, the top level and the testbench.
// No dependencies.
package ctt_pkg;

    // Token length limit and the width of the length counter
    localparam int MaxTokenLen = 1023;
    localparam int LenW        = $clog2(MaxTokenLen + 1);

    // Results one input word can cause, and the width of that count
    localparam int MaxRes  = 4;
    localparam int ResCntW = $clog2(MaxRes + 1);

    // Result queue geometry
    localparam int QDepth = 8;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Reset value of the argument limit register
    localparam logic [7:0] ArgLimitReset = 8'd80;

    // Lexer modes
    localparam logic [2:0] ModeEmpty   = 3'd0;
    localparam logic [2:0] ModeBetween = 3'd1;
    localparam logic [2:0] ModeSlash   = 3'd2;
    localparam logic [2:0] ModeWord    = 3'd3;
    localparam logic [2:0] ModeQuote   = 3'd4;
    localparam logic [2:0] ModeDiscard = 3'd5;

    // Result event codes
    localparam logic [1:0] EvChar   = 2'd0;
    localparam logic [1:0] EvTokEnd = 2'd1;
    localparam logic [1:0] EvCmdEnd = 2'd2;

    // Input kinds
    localparam logic KindText  = 1'b0;
    localparam logic KindFlush = 1'b1;

    // Characters the lexer looks for
    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChApos   = 8'h27;
    localparam logic [7:0] ChLparen = 8'h28;
    localparam logic [7:0] ChRparen = 8'h29;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChLbrace = 8'h7B;
    localparam logic [7:0] ChRbrace = 8'h7D;

    // One result word
    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] ch;
        logic [7:0] idx;
        logic       trunc;
        logic       last;
    } t_res;

    // Results of one input word, handed from the lexer to the queue
    typedef struct packed {
        logic [ResCntW-1:0]     n;
        t_res [MaxRes-1:0]      res;
    } t_push;

endpackage

// ===== src/ctt_if.sv =====
// Valid/ready channel interfaces of the console command tokenizer.
// No dependencies; nothing from ctt_pkg is used.
interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface ctt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] char_value;
    logic [7:0] arg_index;
    logic       truncated;
    logic       last;

    modport source (output valid, output event_res, output char_value, output arg_index,
                    output truncated, output last, input ready);
    modport sink   (input valid, input event_res, input char_value, input arg_index,
                    input truncated, input last, output ready);
endinterface

// ===== src/ctt_lexer.sv =====
// Lexer of the console command tokenizer: lexer state, argument limit register
// and the one-pass per-byte update that yields up to four results. Uses ctt_pkg.
module ctt_lexer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    output ctt_pkg::t_push    o_push
);

    typedef struct packed {
        logic [2:0]              mode;
        logic                    parity;
        logic [7:0]              cnt;
        logic [ctt_pkg::LenW-1:0] len;
        logic                    ovf;
    } t_lex_st;

    typedef struct packed {
        t_lex_st                                 st;
        logic [ctt_pkg::ResCntW-1:0]             n;
        ctt_pkg::t_res [ctt_pkg::MaxRes-1:0]     res;
    } t_work;

    t_lex_st    r_st;
    t_lex_st    n_st;
    logic [7:0] r_arg_limit;
    t_work      w_work;

    // Append one result
    function automatic t_work f_put(input t_work w, input logic [1:0] ev,
                                    input logic [7:0] ch, input logic tr);
        t_work r;
        r = w;
        if (r.n < ctt_pkg::ResCntW'(ctt_pkg::MaxRes)) begin
            r.res[r.n[$clog2(ctt_pkg::MaxRes)-1:0]] =
                '{ev: ev, ch: ch, idx: r.st.cnt, trunc: tr, last: 1'b0};
            r.n = r.n + ctt_pkg::ResCntW'(1);
        end
        return r;
    endfunction

    // Keep a token character, or drop it past the length limit
    function automatic t_work f_tok_char(input t_work w, input logic [7:0] b,
                                         input logic [7:0] lim);
        t_work r;
        r = w;
        if (r.st.len < ctt_pkg::LenW'(ctt_pkg::MaxTokenLen)) begin
            r.st.len = r.st.len + ctt_pkg::LenW'(1);
            if (r.st.cnt < lim) begin
                r = f_put(r, ctt_pkg::EvChar, b, 1'b0);
            end
        end else begin
            r.st.ovf = 1'b1;
        end
        return r;
    endfunction

    // Close the current token
    function automatic t_work f_tok_end(input t_work w, input logic [7:0] lim);
        t_work r;
        r = w;
        if (r.st.cnt < lim) begin
            r = f_put(r, ctt_pkg::EvTokEnd, 8'h00, r.st.ovf);
            if (r.st.cnt != 8'hFF) begin
                r.st.cnt = r.st.cnt + 8'd1;
            end
        end
        r.st.len = '0;
        r.st.ovf = 1'b0;
        return r;
    endfunction

    function automatic logic f_is_punct(input logic [7:0] b);
        return (b == ctt_pkg::ChLbrace) || (b == ctt_pkg::ChRbrace) ||
               (b == ctt_pkg::ChRparen) || (b == ctt_pkg::ChLparen) ||
               (b == ctt_pkg::ChApos)   || (b == ctt_pkg::ChColon);
    endfunction

    // A byte that continues a word
    function automatic t_work f_word_byte(input t_work w, input logic [7:0] b,
                                          input logic [7:0] lim);
        t_work r;
        r = w;
        if (b == ctt_pkg::ChNul) begin
            r = f_tok_end(r, lim);
            r.st.mode = ctt_pkg::ModeDiscard;
        end else if (b <= ctt_pkg::ChSpace) begin
            r = f_tok_end(r, lim);
            r.st.mode = ctt_pkg::ModeBetween;
        end else if (f_is_punct(b)) begin
            r = f_tok_end(r, lim);
            r = f_tok_char(r, b, lim);
            r = f_tok_end(r, lim);
            r.st.mode = ctt_pkg::ModeBetween;
        end else begin
            r = f_tok_char(r, b, lim);
        end
        return r;
    endfunction

    // Finish any open token, then end the command
    function automatic t_work f_cmd_end(input t_work w, input logic [7:0] lim);
        t_work r;
        r = w;
        if (r.st.mode == ctt_pkg::ModeSlash) begin
            r = f_tok_char(r, ctt_pkg::ChSlash, lim);
            r = f_tok_end(r, lim);
        end else if (r.st.mode == ctt_pkg::ModeWord || r.st.mode == ctt_pkg::ModeQuote) begin
            r = f_tok_end(r, lim);
        end
        r = f_put(r, ctt_pkg::EvCmdEnd, 8'h00, 1'b0);
        r.st = '{mode: ctt_pkg::ModeEmpty, parity: 1'b0, cnt: 8'd0, len: '0, ovf: 1'b0};
        return r;
    endfunction

    // Per-byte update
    always_comb begin
        w_work     = '0;
        w_work.st  = r_st;
        if (i_kind == ctt_pkg::KindFlush) begin
            if (r_st.mode != ctt_pkg::ModeEmpty) begin
                w_work = f_cmd_end(w_work, r_arg_limit);
            end
        end else if (i_byte == ctt_pkg::ChLf || i_byte == ctt_pkg::ChCr ||
                     (i_byte == ctt_pkg::ChSemi && !r_st.parity)) begin
            w_work = f_cmd_end(w_work, r_arg_limit);
        end else begin
            if (i_byte == ctt_pkg::ChQuote) begin
                w_work.st.parity = ~r_st.parity;
            end
            unique case (r_st.mode)
                ctt_pkg::ModeEmpty, ctt_pkg::ModeBetween: begin
                    w_work.st.mode = ctt_pkg::ModeBetween;
                    if (i_byte == ctt_pkg::ChNul) begin
                        w_work.st.mode = ctt_pkg::ModeDiscard;
                    end else if (i_byte <= ctt_pkg::ChSpace) begin
                        // whitespace between tokens is skipped
                    end else if (i_byte == ctt_pkg::ChSlash) begin
                        w_work.st.mode = ctt_pkg::ModeSlash;
                    end else if (i_byte == ctt_pkg::ChQuote) begin
                        w_work.st.len  = '0;
                        w_work.st.ovf  = 1'b0;
                        w_work.st.mode = ctt_pkg::ModeQuote;
                    end else if (f_is_punct(i_byte)) begin
                        w_work = f_tok_char(w_work, i_byte, r_arg_limit);
                        w_work = f_tok_end(w_work, r_arg_limit);
                    end else begin
                        w_work = f_tok_char(w_work, i_byte, r_arg_limit);
                        w_work.st.mode = ctt_pkg::ModeWord;
                    end
                end
                ctt_pkg::ModeSlash: begin
                    if (i_byte == ctt_pkg::ChSlash) begin
                        w_work.st.mode = ctt_pkg::ModeDiscard;
                    end else begin
                        // held slash turns out to start a word
                        w_work = f_tok_char(w_work, ctt_pkg::ChSlash, r_arg_limit);
                        w_work.st.mode = ctt_pkg::ModeWord;
                        w_work = f_word_byte(w_work, i_byte, r_arg_limit);
                    end
                end
                ctt_pkg::ModeWord: begin
                    w_work = f_word_byte(w_work, i_byte, r_arg_limit);
                end
                ctt_pkg::ModeQuote: begin
                    if (i_byte == ctt_pkg::ChQuote) begin
                        w_work = f_tok_end(w_work, r_arg_limit);
                        w_work.st.mode = ctt_pkg::ModeBetween;
                    end else if (i_byte == ctt_pkg::ChNul) begin
                        w_work = f_tok_end(w_work, r_arg_limit);
                        w_work.st.mode = ctt_pkg::ModeDiscard;
                    end else begin
                        w_work = f_tok_char(w_work, i_byte, r_arg_limit);
                    end
                end
                default: begin
                    w_work.st.mode = ctt_pkg::ModeDiscard;
                end
            endcase
        end
    end

    // Flag the final result of the word and gate on acceptance
    always_comb begin
        o_push.res = w_work.res;
        o_push.n   = i_step ? w_work.n : '0;
        n_st       = i_step ? w_work.st : r_st;
        for (int k = 0; k < ctt_pkg::MaxRes; k++) begin
            if (ctt_pkg::ResCntW'(k + 1) == w_work.n) begin
                o_push.res[k].last = 1'b1;
            end
        end
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '{mode: ctt_pkg::ModeEmpty, parity: 1'b0, cnt: 8'd0,
                             len: '0, ovf: 1'b0};
            r_arg_limit <= ctt_pkg::ArgLimitReset;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                r_arg_limit <= i_cfg_wdata;
            end
        end
    end

`ifndef SYNTH
    // a word never yields more results than the queue reserves
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.n <= ctt_pkg::ResCntW'(ctt_pkg::MaxRes))
        else $error("lexer produced too many results");

    // exactly one result of a word carries last
    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.n != '0 |-> $countones({o_push.res[3].last, o_push.res[2].last,
                                       o_push.res[1].last, o_push.res[0].last}) == 1)
        else $error("last flag not unique");

    // a newline always closes the command and clears the count
    a_lf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_kind == ctt_pkg::KindText && i_byte == ctt_pkg::ChLf |=>
        r_st.mode == ctt_pkg::ModeEmpty && r_st.cnt == 8'd0 && !r_st.parity)
        else $error("newline did not end the command");
`endif

endmodule

// ===== src/ctt_res_queue.sv =====
// Result queue of the console command tokenizer: takes up to four result words
// per cycle from the lexer and delivers one per handshake. Uses ctt_pkg.
module ctt_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctt_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    output ctt_pkg::t_res    o_head,
    input  logic             i_pop
);

    ctt_pkg::t_res                  r_q [ctt_pkg::QDepth];
    logic [ctt_pkg::QPtrW-1:0]      r_wr_ptr;
    logic [ctt_pkg::QPtrW-1:0]      r_rd_ptr;
    logic [ctt_pkg::QCntW-1:0]      r_cnt;
    logic                           w_pop;

    // Room for a full set of results from one word
    assign o_space = r_cnt <= ctt_pkg::QCntW'(ctt_pkg::QDepth - ctt_pkg::MaxRes);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_q[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    // Storage writes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ctt_pkg::MaxRes; k++) begin
            if (ctt_pkg::ResCntW'(k) < i_push.n) begin
                r_q[r_wr_ptr + ctt_pkg::QPtrW'(k)] <= i_push.res[k];
            end
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ctt_pkg::QPtrW'(i_push.n);
            r_rd_ptr <= r_rd_ptr + ctt_pkg::QPtrW'(w_pop);
            r_cnt    <= r_cnt + ctt_pkg::QCntW'(i_push.n) - ctt_pkg::QCntW'(w_pop);
        end
    end

`ifndef SYNTH
    // never more words stored than entries
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ctt_pkg::QCntW'(ctt_pkg::QDepth))
        else $error("result queue overflow");

    // results only arrive when space was advertised
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != '0 |-> o_space)
        else $error("push without space");

    // fill count tracks pushes and pops
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_cnt == $past(r_cnt) + ctt_pkg::QCntW'($past(i_push.n))
                          - ctt_pkg::QCntW'($past(w_pop)))
        else $error("fill count mismatch");
`endif

endmodule

// ===== src/console_command_tokenizer_top.sv =====
// Console command tokenizer top level: one byte word per cycle in while there
// is queue space, token and command event words out through a result queue.
// Uses ctt_pkg, ctt_if, ctt_lexer and ctt_res_queue.
// The results of a byte are registered in the queue when the byte is accepted.
// Throughput: one byte per cycle while the queue has room; output drains one
// word per cycle while ready is high; a byte yields up to 4 words (queue of 8).
// Reset: synchronous active low; empties the queue, clears the lexer, limit 80.
module console_command_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    ctt_in_if.sink      i_in,
    ctt_out_if.source   o_out
);

    ctt_pkg::t_push w_push;
    ctt_pkg::t_res  w_head;
    logic           w_space;
    logic           w_valid;
    logic           w_step;

    // Input handshake
    assign i_in.ready = w_space;
    assign w_step     = i_in.valid && w_space;

    ctt_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_kind     (i_in.kind),
        .i_byte     (i_in.byte_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_push     (w_push)
    );

    ctt_res_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_space(w_space),
        .o_valid(w_valid),
        .o_head (w_head),
        .i_pop  (o_out.ready)
    );

    // Output word
    assign o_out.valid      = w_valid;
    assign o_out.event_res  = w_head.ev;
    assign o_out.char_value = w_head.ch;
    assign o_out.arg_index  = w_head.idx;
    assign o_out.truncated  = w_head.trunc;
    assign o_out.last       = w_head.last;

endmodule

// ===== dv/console_command_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of console_command_tokenizer_top: a directed table, then random
// scripts, checked against a behavioral tokenizer. Depends on ctt_pkg, ctt_if and the RTL.
module console_command_tokenizer_top_tb;

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 4;
    localparam int MaxReports  = 10;

    // One row of the directed table; res is only meaningful when typed and has_res
    typedef struct packed {
        logic          typed;
        logic          kind;
        logic [7:0]    val;
        logic          has_res;
        ctt_pkg::t_res res;
    } t_row;

    localparam ctt_pkg::t_res NoRes   = '0;
    localparam int            NumRows = 28;
    localparam t_row DirectedRows [NumRows] = '{
        '{1'b1, ctt_pkg::KindFlush, 8'hFF, 1'b0, NoRes},
        '{1'b1, ctt_pkg::KindText, 8'h61, 1'b1, '{ctt_pkg::EvChar, 8'h61, 8'd0, 1'b0, 1'b1}},
        '{1'b1, ctt_pkg::KindText, 8'hFF, 1'b1, '{ctt_pkg::EvChar, 8'hFF, 8'd0, 1'b0, 1'b1}},
        '{1'b1, ctt_pkg::KindText, ctt_pkg::ChSpace, 1'b1,
          '{ctt_pkg::EvTokEnd, 8'h00, 8'd0, 1'b0, 1'b1}},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChQuote, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChSemi, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChQuote, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChLbrace, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChSlash, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, 8'h78, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChRparen, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChSlash, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChSlash, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChQuote, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChSemi, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChLf, 1'b0, NoRes},
        '{1'b1, ctt_pkg::KindText, ctt_pkg::ChSemi, 1'b1,
          '{ctt_pkg::EvCmdEnd, 8'h00, 8'd0, 1'b0, 1'b1}},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChSlash, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChCr, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, 8'h80, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChNul, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChRbrace, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChSemi, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChQuote, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, ctt_pkg::ChColon, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindFlush, 8'h00, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindText, 8'h01, 1'b0, NoRes},
        '{1'b0, ctt_pkg::KindFlush, 8'h00, 1'b0, NoRes}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    ctt_in_if  in_ch ();
    ctt_out_if out_ch ();

    console_command_tokenizer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Tokenizer state mirrored by the predictor
    logic [7:0]               limit_reg;
    logic [2:0]               lex_state;
    logic                     quote_odd;
    logic [7:0]               tok_count;
    logic [ctt_pkg::LenW-1:0] tok_len;
    logic                     tok_dropped;

    ctt_pkg::t_res step_events [$];
    ctt_pkg::t_res pending_events [$];

    // Directed rows with a typed expectation bypass the predictor output
    logic          use_typed;
    logic          typed_has;
    ctt_pkg::t_res typed_word;

    int   mismatch_count;
    int   cycle_count;
    int   items_sent;
    int   sink_hold;
    logic src_idle_en;
    logic sink_idle_en;

    // ---------------- predictor ----------------

    function automatic void add_event(input logic [1:0] ev, input logic [7:0] ch,
                                      input logic [7:0] idx, input logic tr);
        ctt_pkg::t_res r;
        r.ev    = ev;
        r.ch    = ch;
        r.idx   = idx;
        r.trunc = tr;
        r.last  = 1'b0;
        step_events.push_back(r);
    endfunction

    function automatic logic arg_reported();
        return tok_count < limit_reg;
    endfunction

    function automatic void add_token_char(input logic [7:0] b);
        if (tok_len < ctt_pkg::LenW'(ctt_pkg::MaxTokenLen)) begin
            tok_len = tok_len + 1'b1;
            if (arg_reported())
                add_event(ctt_pkg::EvChar, b, tok_count, 1'b0);
        end else begin
            tok_dropped = 1'b1;
        end
    endfunction

    function automatic void close_token();
        if (arg_reported()) begin
            add_event(ctt_pkg::EvTokEnd, 8'h00, tok_count, tok_dropped);
            if (tok_count < 8'd255)
                tok_count = tok_count + 1'b1;
        end
        tok_len     = '0;
        tok_dropped = 1'b0;
    endfunction

    function automatic logic is_one_char_token(input logic [7:0] b);
        return b == ctt_pkg::ChLbrace || b == ctt_pkg::ChRbrace ||
               b == ctt_pkg::ChRparen || b == ctt_pkg::ChLparen ||
               b == ctt_pkg::ChApos || b == ctt_pkg::ChColon;
    endfunction

    // Finish any open token, then report the command and start over
    function automatic void close_command();
        if (lex_state == ctt_pkg::ModeSlash) begin
            add_token_char(ctt_pkg::ChSlash);
            close_token();
        end else if (lex_state == ctt_pkg::ModeWord || lex_state == ctt_pkg::ModeQuote) begin
            close_token();
        end
        add_event(ctt_pkg::EvCmdEnd, 8'h00, tok_count, 1'b0);
        lex_state   = ctt_pkg::ModeEmpty;
        quote_odd   = 1'b0;
        tok_count   = '0;
        tok_len     = '0;
        tok_dropped = 1'b0;
    endfunction

    function automatic void continue_word(input logic [7:0] b);
        if (b == ctt_pkg::ChNul) begin
            close_token();
            lex_state = ctt_pkg::ModeDiscard;
        end else if (b <= ctt_pkg::ChSpace) begin
            close_token();
            lex_state = ctt_pkg::ModeBetween;
        end else if (is_one_char_token(b)) begin
            close_token();
            add_token_char(b);
            close_token();
            lex_state = ctt_pkg::ModeBetween;
        end else begin
            add_token_char(b);
        end
    endfunction

    // Results of one input word land in step_events, last flag on the final one
    function automatic void tokenize_byte(input logic k, input logic [7:0] b);
        ctt_pkg::t_res r;
        step_events.delete();
        if (k == ctt_pkg::KindFlush) begin
            if (lex_state != ctt_pkg::ModeEmpty)
                close_command();
        end else if (b == ctt_pkg::ChLf || b == ctt_pkg::ChCr ||
                     (b == ctt_pkg::ChSemi && !quote_odd)) begin
            close_command();
        end else begin
            if (b == ctt_pkg::ChQuote)
                quote_odd = ~quote_odd;
            case (lex_state)
                ctt_pkg::ModeEmpty, ctt_pkg::ModeBetween: begin
                    lex_state = ctt_pkg::ModeBetween;
                    if (b == ctt_pkg::ChNul) begin
                        lex_state = ctt_pkg::ModeDiscard;
                    end else if (b <= ctt_pkg::ChSpace) begin
                        // blank, skipped
                    end else if (b == ctt_pkg::ChSlash) begin
                        lex_state = ctt_pkg::ModeSlash;
                    end else if (b == ctt_pkg::ChQuote) begin
                        tok_len     = '0;
                        tok_dropped = 1'b0;
                        lex_state   = ctt_pkg::ModeQuote;
                    end else if (is_one_char_token(b)) begin
                        add_token_char(b);
                        close_token();
                    end else begin
                        add_token_char(b);
                        lex_state = ctt_pkg::ModeWord;
                    end
                end
                ctt_pkg::ModeSlash: begin
                    if (b == ctt_pkg::ChSlash) begin
                        lex_state = ctt_pkg::ModeDiscard;
                    end else begin
                        add_token_char(ctt_pkg::ChSlash);
                        lex_state = ctt_pkg::ModeWord;
                        continue_word(b);
                    end
                end
                ctt_pkg::ModeWord: continue_word(b);
                ctt_pkg::ModeQuote: begin
                    if (b == ctt_pkg::ChQuote) begin
                        close_token();
                        lex_state = ctt_pkg::ModeBetween;
                    end else if (b == ctt_pkg::ChNul) begin
                        close_token();
                        lex_state = ctt_pkg::ModeDiscard;
                    end else begin
                        add_token_char(b);
                    end
                end
                default: lex_state = ctt_pkg::ModeDiscard;
            endcase
        end
        if (step_events.size() > 0) begin
            r = step_events.pop_back();
            r.last = 1'b1;
            step_events.push_back(r);
        end
    endfunction

    // ---------------- driving ----------------

    // Offer one word; returns at the edge that accepted it, valid still high
    task automatic send_word(input logic k, input logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= k;
        in_ch.byte_value <= b;
        @(negedge i_clk);
        while (in_ch.ready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        tokenize_byte(k, b);
        if (use_typed) begin
            if (typed_has)
                pending_events.push_back(typed_word);
            use_typed = 1'b0;
        end else begin
            foreach (step_events[i]) pending_events.push_back(step_events[i]);
        end
        items_sent++;
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_arg_limit(input logic [7:0] value);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        limit_reg = value;
    endtask

    function automatic logic [7:0] blank_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 32)); while (c == ctt_pkg::ChLf || c == ctt_pkg::ChCr);
        return c;
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255));
        while (c == ctt_pkg::ChQuote || c == ctt_pkg::ChSemi);
        return c;
    endfunction

    function automatic logic [7:0] any_inner_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == ctt_pkg::ChQuote || c == ctt_pkg::ChLf || c == ctt_pkg::ChCr);
        return c;
    endfunction

    function automatic logic [7:0] one_char_token();
        case ($urandom_range(0, 5))
            0:       return ctt_pkg::ChLbrace;
            1:       return ctt_pkg::ChRbrace;
            2:       return ctt_pkg::ChLparen;
            3:       return ctt_pkg::ChRparen;
            4:       return ctt_pkg::ChApos;
            default: return ctt_pkg::ChColon;
        endcase
    endfunction

    // A mostly well-formed command with random content and a random terminator
    task automatic send_random_command();
        int   ntok;
        int   sel;
        logic open_quote;
        ntok       = $urandom_range(0, 6);
        open_quote = 1'b0;
        for (int t = 0; t < ntok && !open_quote; t++) begin
            if ($urandom_range(0, 3) != 0)
                send_word(ctt_pkg::KindText, blank_byte());
            sel = $urandom_range(0, 19);
            if (sel < 8) begin
                repeat ($urandom_range(1, 6)) send_word(ctt_pkg::KindText, word_byte());
            end else if (sel < 12 || sel == 19) begin
                send_word(ctt_pkg::KindText, ctt_pkg::ChQuote);
                repeat ($urandom_range(0, 5)) send_word(ctt_pkg::KindText, any_inner_byte());
                if (sel == 19)
                    open_quote = 1'b1;
                else
                    send_word(ctt_pkg::KindText, ctt_pkg::ChQuote);
            end else if (sel < 15) begin
                send_word(ctt_pkg::KindText, one_char_token());
            end else if (sel == 15) begin
                send_word(ctt_pkg::KindText, ctt_pkg::ChSlash);
                send_word(ctt_pkg::KindText, word_byte());
            end else if (sel == 16) begin
                // comment swallows the rest of the command
                send_word(ctt_pkg::KindText, ctt_pkg::ChSlash);
                send_word(ctt_pkg::KindText, ctt_pkg::ChSlash);
                repeat ($urandom_range(0, 4)) send_word(ctt_pkg::KindText, any_inner_byte());
            end else if (sel == 17) begin
                send_word(ctt_pkg::KindText, ctt_pkg::ChNul);
                send_word(ctt_pkg::KindText, word_byte());
            end else begin
                send_word(ctt_pkg::KindText, ctt_pkg::ChSlash);
                send_word(ctt_pkg::KindText, blank_byte());
            end
        end
        sel = $urandom_range(0, 10);
        if (sel < 5)
            send_word(ctt_pkg::KindText, ctt_pkg::ChLf);
        else if (sel < 8)
            send_word(ctt_pkg::KindText, ctt_pkg::ChCr);
        else if (sel < 10)
            send_word(ctt_pkg::KindText, ctt_pkg::ChSemi);
        else
            send_word(ctt_pkg::KindFlush, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int count, input int calm_tail);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if (items_sent >= stop_at - calm_tail) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            // noise: any byte, or an end of text with random byte bits
            if ($urandom_range(0, 7) == 0)
                send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else
                send_random_command();
        end
    endtask

    // ---------------- checking ----------------

    always @(negedge i_clk) begin : check_results
        ctt_pkg::t_res got;
        ctt_pkg::t_res want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.ev    = out_ch.event_res;
            got.ch    = out_ch.char_value;
            got.idx   = out_ch.arg_index;
            got.trunc = out_ch.truncated;
            got.last  = out_ch.last;
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MaxReports)
                    $display("unexpected word: ev=%0d ch=%02h idx=%0d trunc=%0b last=%0b",
                             got.ev, got.ch, got.idx, got.trunc, got.last);
            end else begin
                want = pending_events.pop_front();
                if (got.ev !== want.ev || got.ch !== want.ch || got.idx !== want.idx ||
                    got.trunc !== want.trunc || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports)
                        $display("mismatch: exp ev=%0d ch=%02h idx=%0d trunc=%0b last=%0b, ",
                                 want.ev, want.ch, want.idx, want.trunc, want.last,
                                 "got ev=%0d ch=%02h idx=%0d trunc=%0b last=%0b",
                                 got.ev, got.ch, got.idx, got.trunc, got.last);
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold when requested
    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                out_ch.ready <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 8'h00;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= ctt_pkg::KindText;
        in_ch.byte_value <= 8'h00;
        limit_reg      = ctt_pkg::ArgLimitReset;
        lex_state      = ctt_pkg::ModeEmpty;
        quote_odd      = 1'b0;
        tok_count      = '0;
        tok_len        = '0;
        tok_dropped    = 1'b0;
        use_typed      = 1'b0;
        typed_has      = 1'b0;
        typed_word     = NoRes;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        sink_hold      = 0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset limit
        foreach (DirectedRows[i]) begin
            use_typed  = DirectedRows[i].typed;
            typed_has  = DirectedRows[i].has_res;
            typed_word = DirectedRows[i].res;
            send_word(DirectedRows[i].kind, DirectedRows[i].val);
        end

        // over-long word and over-long quoted token, both truncated
        send_word(ctt_pkg::KindText, ctt_pkg::ChLf);
        for (int i = 0; i < ctt_pkg::MaxTokenLen + 7; i++)
            send_word(ctt_pkg::KindText, 8'h41 + 8'(i % 26));
        send_word(ctt_pkg::KindText, ctt_pkg::ChSpace);
        send_word(ctt_pkg::KindText, ctt_pkg::ChQuote);
        for (int i = 0; i < ctt_pkg::MaxTokenLen + 1; i++)
            send_word(ctt_pkg::KindText, 8'h61 + 8'(i % 26));
        send_word(ctt_pkg::KindText, ctt_pkg::ChQuote);
        send_word(ctt_pkg::KindText, ctt_pkg::ChLf);

        write_arg_limit(8'd1);
        run_random(100, 0);

        // top limit; receiver holds off while the sender keeps offering tokens
        write_arg_limit(8'd255);
        send_word(ctt_pkg::KindText, ctt_pkg::ChLf);
        sink_hold = 80;
        repeat (260) send_word(ctt_pkg::KindText, one_char_token());
        send_word(ctt_pkg::KindText, ctt_pkg::ChLf);
        wait_for_drain();

        write_arg_limit(8'($urandom_range(2, 6)));
        run_random(150, 0);

        write_arg_limit(ctt_pkg::ArgLimitReset);
        run_random(160, 60);

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
